// ===== rtl/mrpt_pkg.sv =====
// Shared types and constants for the Miller-Rabin primality tester.
`default_nettype none
package mrpt_pkg;
	localparam int WordBits = 64;
	localparam int NumBases = 12;
	localparam int BaseIdxBits = 4;
	localparam int BitIdxBits = 6;

	typedef logic [WordBits-1:0] word_t;

	// Datapath operations issued by the controller.
	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_LOAD  = 3'd1,
		OP_SPLIT = 3'd2,
		OP_BASE  = 3'd3,
		OP_MULRB = 3'd4,
		OP_MULBB = 3'd5,
		OP_MULVV = 3'd6
	} dp_op_t;

	typedef struct packed {
		dp_op_t                 op;
		logic [BaseIdxBits-1:0] base_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic n_lt2;
		logic n_is_base;
		logic d_odd;
		logic e_zero;
		logic e_lsb;
		logic v_is_one;
		logic v_is_nm1;
		logic r_lt_s;
	} dp_stat_t;

	function automatic word_t base_value(input logic [BaseIdxBits-1:0] idx);
		word_t v;
		v = '0;
		unique case (idx)
			4'd0:    v = word_t'(2);
			4'd1:    v = word_t'(3);
			4'd2:    v = word_t'(5);
			4'd3:    v = word_t'(7);
			4'd4:    v = word_t'(11);
			4'd5:    v = word_t'(13);
			4'd6:    v = word_t'(17);
			4'd7:    v = word_t'(19);
			4'd8:    v = word_t'(23);
			4'd9:    v = word_t'(29);
			4'd10:   v = word_t'(31);
			4'd11:   v = word_t'(37);
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/mrpt_datapath.sv =====
// Datapath: operand registers and a bit-serial modular multiplier.
`default_nettype none
module mrpt_datapath (
	input  wire                  clk,
	input  wire                  arst_n,
	input  mrpt_pkg::word_t      candidate,
	input  mrpt_pkg::dp_cmd_t    cmd,
	output mrpt_pkg::dp_stat_t   stat
);
	import mrpt_pkg::*;

	word_t n_q, d_q, e_q, b_q, v_q;
	logic [BitIdxBits:0] s_q, r_q;
	word_t acc_q, ma_q, mb_q;
	logic [BitIdxBits-1:0] bit_q;
	logic busy_q;
	logic mul_done_q;
	logic [1:0] dst_q;

	word_t dbl, sum, nxt;
	logic [WordBits:0] t1, t2;
	word_t bv;

	// acc = 2*acc mod n, then + a mod n when the bit is set
	always_comb begin
		t1 = {1'b0, acc_q} + {1'b0, acc_q};
		dbl = (t1 >= {1'b0, n_q}) ? word_t'(t1 - {1'b0, n_q}) : t1[WordBits-1:0];
		t2 = {1'b0, dbl} + {1'b0, ma_q};
		sum = (t2 >= {1'b0, n_q}) ? word_t'(t2 - {1'b0, n_q}) : t2[WordBits-1:0];
		nxt = mb_q[bit_q] ? sum : dbl;
		bv = base_value(cmd.base_idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mul_done_q <= 1'b0;
			n_q <= '0;
			d_q <= '0;
			e_q <= '0;
			b_q <= '0;
			v_q <= '0;
			s_q <= '0;
			r_q <= '0;
			acc_q <= '0;
			ma_q <= '0;
			mb_q <= '0;
			bit_q <= '0;
			dst_q <= '0;
		end else begin
			mul_done_q <= 1'b0;
			if (busy_q) begin
				acc_q <= nxt;
				bit_q <= bit_q - 1'b1;
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					mul_done_q <= 1'b1;
					unique case (dst_q)
						2'd0: v_q <= nxt;
						2'd1: b_q <= nxt;
						default: begin
							v_q <= nxt;
							r_q <= r_q + 1'b1;
						end
					endcase
				end
			end else begin
				unique case (cmd.op)
					OP_LOAD: begin
						n_q <= candidate;
						d_q <= candidate - 1'b1;
						s_q <= '0;
					end
					OP_SPLIT: begin
						d_q <= d_q >> 1;
						s_q <= s_q + 1'b1;
					end
					OP_BASE: begin
						// candidates below a base stop earlier, so one subtract reduces it
						b_q <= (bv >= n_q) ? bv - n_q : bv;
						e_q <= d_q;
						v_q <= word_t'(1);
						r_q <= (BitIdxBits+1)'(1);
					end
					OP_MULRB, OP_MULBB, OP_MULVV: begin
						busy_q <= 1'b1;
						acc_q <= '0;
						bit_q <= '1;
						ma_q <= (cmd.op == OP_MULRB) ? v_q : (cmd.op == OP_MULBB) ? b_q : v_q;
						mb_q <= (cmd.op == OP_MULRB || cmd.op == OP_MULBB) ? b_q : v_q;
						dst_q <= (cmd.op == OP_MULRB) ? 2'd0 : (cmd.op == OP_MULBB) ? 2'd1 : 2'd2;
						if (cmd.op == OP_MULBB) e_q <= e_q >> 1;
					end
					default: ;
				endcase
			end
		end
	end

	assign stat.mul_done = mul_done_q;
	assign stat.n_lt2 = n_q < word_t'(2);
	assign stat.n_is_base = n_q == bv;
	assign stat.d_odd = d_q[0];
	assign stat.e_zero = e_q == '0;
	assign stat.e_lsb = e_q[0];
	assign stat.v_is_one = v_q == word_t'(1);
	assign stat.v_is_nm1 = v_q == n_q - 1'b1;
	assign stat.r_lt_s = r_q < s_q;
endmodule
`default_nettype wire

// ===== rtl/mrpt_ctrl.sv =====
// Controller: sequences bases, exponentiation and squaring.
`default_nettype none
module mrpt_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	output logic                 done,
	output logic                 prime_flag,
	output mrpt_pkg::dp_cmd_t    cmd,
	input  mrpt_pkg::dp_stat_t   stat
);
	import mrpt_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_CHECK = 10'b0000000010,
		ST_SPLIT = 10'b0000000100,
		ST_BASE  = 10'b0000001000,
		ST_POW   = 10'b0000010000,
		ST_WRB   = 10'b0000100000,
		ST_WBB   = 10'b0001000000,
		ST_TEST  = 10'b0010000000,
		ST_WSQ   = 10'b0100000000,
		ST_SQ    = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [BaseIdxBits-1:0] idx_q;

	assign busy = state_q != ST_IDLE;

	always_comb begin
		cmd.op = OP_NONE;
		cmd.base_idx = idx_q;
		unique case (state_q)
			ST_IDLE:  cmd.op = start ? OP_LOAD : OP_NONE;
			ST_SPLIT: cmd.op = stat.d_odd ? OP_NONE : OP_SPLIT;
			ST_BASE:  cmd.op = stat.n_is_base ? OP_NONE : OP_BASE;
			ST_POW:   cmd.op = stat.e_zero ? OP_NONE : (stat.e_lsb ? OP_MULRB : OP_MULBB);
			ST_WRB:   cmd.op = stat.mul_done ? OP_MULBB : OP_NONE;
			ST_SQ:    cmd.op = OP_MULVV;
			default:  cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			done <= 1'b0;
			prime_flag <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (start) begin
					state_q <= ST_CHECK;
					idx_q <= '0;
				end
				ST_CHECK: if (stat.n_lt2) begin
					done <= 1'b1; prime_flag <= 1'b0; state_q <= ST_IDLE;
				end else state_q <= ST_SPLIT;
				ST_SPLIT: if (stat.d_odd) state_q <= ST_BASE;
				ST_BASE: if (idx_q == BaseIdxBits'(NumBases) || stat.n_is_base) begin
					done <= 1'b1; prime_flag <= 1'b1; state_q <= ST_IDLE;
				end else state_q <= ST_POW;
				ST_POW: if (stat.e_zero) state_q <= ST_TEST;
				else state_q <= stat.e_lsb ? ST_WRB : ST_WBB;
				ST_WRB: if (stat.mul_done) state_q <= ST_WBB;
				ST_WBB: if (stat.mul_done) state_q <= ST_POW;
				ST_TEST: if (stat.v_is_one || stat.v_is_nm1) begin
					idx_q <= idx_q + 1'b1; state_q <= ST_BASE;
				end else if (stat.r_lt_s) state_q <= ST_SQ;
				else begin
					done <= 1'b1; prime_flag <= 1'b0; state_q <= ST_IDLE;
				end
				ST_SQ: state_q <= ST_WSQ;
				// square result loops back to the test; the top level masks 1 there, so only n-1 passes
				ST_WSQ: if (stat.mul_done) state_q <= ST_TEST;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/miller_rabin_prime_test64.sv =====
// Top level: deterministic Miller-Rabin test on a 64-bit word.
// Channel | Ports                 | Handshake
// input   | candidate[63:0]       | start, accepted when busy low
// result  | prime_flag            | done, one-cycle strobe
// A modular multiply is issued, steps through the 64 multiplier bits and then
// strobes done. Each exponent bit costs a multiply when the bit is set plus a
// square of the base; twelve bases are tried, and the run time is set by the
// bit-serial multiplier. Reset is asynchronous, active low; the receiver cannot
// stall, busy holds off new words.
`default_nettype none
module miller_rabin_prime_test64 (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	input  wire [63:0] candidate,
	output logic       busy,
	output logic       done,
	output logic       prime_flag
);
	import mrpt_pkg::*;
	dp_cmd_t  cmd;
	dp_stat_t stat;
	dp_stat_t stat_fix;

	mrpt_datapath u_dp (.clk(clk), .arst_n(arst_n), .candidate(candidate),
		.cmd(cmd), .stat(stat));

	// a squared value of 1 never passes: mask it once squaring has begun
	logic sq_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_q <= 1'b0;
		else if (cmd.op == OP_MULVV) sq_q <= 1'b1;
		else if (cmd.op == OP_BASE || cmd.op == OP_LOAD) sq_q <= 1'b0;
	end
	always_comb begin
		stat_fix = stat;
		stat_fix.v_is_one = stat.v_is_one && !sq_q;
	end

	mrpt_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.done(done), .prime_flag(prime_flag), .cmd(cmd), .stat(stat_fix));
endmodule
`default_nettype wire

// ===== rtl/mrpt_checker.sv =====
// Port-level checker for the primality tester, bound to the top level.
`default_nettype none
module mrpt_checker (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire busy,
	input wire done
);
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised after accept");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("busy dropped without result");
endmodule
bind miller_rabin_prime_test64 mrpt_checker u_chk (.clk(clk), .arst_n(arst_n),
	.start(start), .busy(busy), .done(done));
`default_nettype wire
